/* rtl/isu_pkg.sv */
// ----------------------------------------------------------------------------
// isu_pkg
// Shared types and constants for the indexed sequence store.
// ----------------------------------------------------------------------------
package isu_pkg;

	// Field widths of the request and response transactions
	localparam int unsigned OP_W       = 2;
	localparam int unsigned POS_W      = 6;
	localparam int unsigned VAL_W      = 32;
	localparam int unsigned STAT_W     = 2;
	localparam int unsigned CNT_OUT_W  = 7;

	// Default sizing
	localparam int unsigned DEPTH_DEF     = 64;
	localparam int unsigned WORD_BITS_DEF = 32;

	typedef enum logic [OP_W-1:0] {
		OP_APPEND = 2'd0,
		OP_READ   = 2'd1,
		OP_REMOVE = 2'd2,
		OP_WRITE  = 2'd3
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_RANGE = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

endpackage

/* rtl/isu_req_if.sv */
// ----------------------------------------------------------------------------
// isu_req_if
// Request channel: operation, position and word, with valid/ready.
// ----------------------------------------------------------------------------
interface isu_req_if
	import isu_pkg::*;
;
	logic                    valid;
	logic                    ready;
	op_t                     operation;
	logic [POS_W-1:0]        position;
	logic signed [VAL_W-1:0] item_value;

	modport source (output valid, operation, position, item_value, input ready);
	modport sink   (input valid, operation, position, item_value, output ready);
endinterface

/* rtl/isu_rsp_if.sv */
// ----------------------------------------------------------------------------
// isu_rsp_if
// Response channel: returned word, status and entry count, with valid/ready.
// ----------------------------------------------------------------------------
interface isu_rsp_if
	import isu_pkg::*;
;
	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] result_value;
	status_t                 status;
	logic [CNT_OUT_W-1:0]    entry_count;

	modport source (output valid, result_value, status, entry_count, input ready);
	modport sink   (input valid, result_value, status, entry_count, output ready);
endinterface

/* rtl/isu_mem.sv */
// ----------------------------------------------------------------------------
// isu_mem
// Entry storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module isu_mem
	import isu_pkg::*;
#(
	parameter int unsigned DEPTH     = DEPTH_DEF,
	parameter int unsigned WORD_BITS = WORD_BITS_DEF,
	localparam int unsigned AW       = $clog2(DEPTH)
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [AW-1:0]        wr_addr,
	input  logic [WORD_BITS-1:0] wr_data,
	input  logic                 rd_en,
	input  logic [AW-1:0]        rd_addr,
	output logic [WORD_BITS-1:0] rd_data
);

	logic [WORD_BITS-1:0] entries_q [DEPTH];
	logic [WORD_BITS-1:0] rd_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			entries_q[wr_addr] <= wr_data;
		end
	end

	// Read port, data registered while rd_en is high
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= entries_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* rtl/isu_ctrl.sv */
// ----------------------------------------------------------------------------
// isu_ctrl
// Request sequencer: range checks, memory access and the removal shift.
// ----------------------------------------------------------------------------
module isu_ctrl
	import isu_pkg::*;
#(
	parameter int unsigned DEPTH     = DEPTH_DEF,
	parameter int unsigned WORD_BITS = WORD_BITS_DEF,
	localparam int unsigned AW       = $clog2(DEPTH)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	isu_req_if.sink              req,
	isu_rsp_if.source            rsp,
	output logic                 wr_en,
	output logic [AW-1:0]        wr_addr,
	output logic [WORD_BITS-1:0] wr_data,
	output logic                 rd_en,
	output logic [AW-1:0]        rd_addr,
	input  logic [WORD_BITS-1:0] rd_data
);

	localparam int unsigned CW   = $clog2(DEPTH + 1);
	localparam int unsigned CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RDWAIT,
		S_SHIFT,
		S_DONE
	} state_t;

	state_t                  state_q;
	logic [CW-1:0]           count_q;
	logic [AW-1:0]           idx_q;
	op_t                     op_q;
	logic [AW-1:0]           pos_q;
	logic [WORD_BITS-1:0]    val_q;
	logic signed [VAL_W-1:0] res_q;
	status_t                 stat_q;
	logic                    out_valid_q;
	logic signed [VAL_W-1:0] out_value_q;
	status_t                 out_stat_q;
	logic [CNT_OUT_W-1:0]    out_count_q;

	logic                        accept;
	logic                        is_full;
	logic                        range_err;
	logic signed [WORD_BITS-1:0] word_in;
	logic signed [WORD_BITS-1:0] word_rd;
	logic signed [VAL_W-1:0]     word_out;
	logic                        more_after_pos;
	logic                        more_after_idx;
	logic                        out_free;

	// Decode the incoming transaction
	assign accept    = req.valid && req.ready;
	assign is_full   = (count_q == CW'(DEPTH));
	assign range_err = (CMPW'(req.position) >= CMPW'(count_q));
	assign word_in   = WORD_BITS'(req.item_value);

	// Resize the stored word, sign-extended, to the result field
	assign word_rd  = rd_data;
	assign word_out = VAL_W'(word_rd);

	// Shift continuation: count_q is the old count in S_RDWAIT, the new one in S_SHIFT
	assign more_after_pos = ((CW + 1)'(pos_q) + (CW + 1)'(1)) < (CW + 1)'(count_q);
	assign more_after_idx = ((CW + 1)'(idx_q) + (CW + 1)'(1)) < (CW + 1)'(count_q);

	assign out_free  = !out_valid_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE);

	// Memory port control
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = rd_data;
		rd_en   = 1'b0;
		rd_addr = AW'(req.position);
		case (state_q)
			S_IDLE: begin
				if (accept && req.operation == OP_APPEND && !is_full) begin
					wr_en   = 1'b1;
					wr_addr = AW'(count_q);
					wr_data = word_in;
				end
				if (accept && req.operation != OP_APPEND && !range_err) begin
					rd_en = 1'b1;
				end
			end
			S_RDWAIT: begin
				if (op_q == OP_WRITE) begin
					wr_en   = 1'b1;
					wr_addr = pos_q;
					wr_data = val_q;
				end
				if (op_q == OP_REMOVE && more_after_pos) begin
					rd_en   = 1'b1;
					rd_addr = pos_q + AW'(1);
				end
			end
			S_SHIFT: begin
				wr_en   = 1'b1;
				wr_addr = idx_q;
				wr_data = rd_data;
				if (more_after_idx) begin
					rd_en   = 1'b1;
					rd_addr = idx_q + AW'(2);
				end
			end
			default: begin
			end
		endcase
	end

	// Sequencer state, count and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			op_q        <= OP_APPEND;
			pos_q       <= '0;
			val_q       <= '0;
			res_q       <= '0;
			stat_q      <= STAT_OK;
			out_valid_q <= 1'b0;
			out_value_q <= '0;
			out_stat_q  <= STAT_OK;
			out_count_q <= '0;
		end else begin
			// drop the response once taken; in S_DONE the load below decides
			if (rsp.ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q  <= req.operation;
						pos_q <= AW'(req.position);
						val_q <= word_in;
						res_q <= '0;
						if (req.operation == OP_APPEND) begin
							state_q <= S_DONE;
							if (is_full) begin
								stat_q <= STAT_FULL;
							end else begin
								stat_q  <= STAT_OK;
								count_q <= count_q + CW'(1);
							end
						end else if (range_err) begin
							stat_q  <= STAT_RANGE;
							state_q <= S_DONE;
						end else begin
							stat_q  <= STAT_OK;
							state_q <= S_RDWAIT;
						end
					end
				end
				S_RDWAIT: begin
					res_q <= word_out;
					idx_q <= pos_q;
					if (op_q == OP_REMOVE) begin
						count_q <= count_q - CW'(1);
						state_q <= more_after_pos ? S_SHIFT : S_DONE;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_SHIFT: begin
					// advance one entry per cycle
					idx_q <= idx_q + AW'(1);
					if (!more_after_idx) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					// hold until the response slot is free
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_value_q <= res_q;
						out_stat_q  <= stat_q;
						out_count_q <= CNT_OUT_W'(count_q);
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.result_value = out_value_q;
	assign rsp.status       = out_stat_q;
	assign rsp.entry_count  = out_count_q;

endmodule

/* rtl/indexed_sequence_store_unit.sv */
// ----------------------------------------------------------------------------
// indexed_sequence_store_unit
// Bounded ordered list of signed words held in one synchronous memory.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request per transaction: append, read at index, remove
//   at index, or overwrite at index. rsp returns exactly one transaction per
//   request, in order, with the returned word, a status and the entry count.
// Path (accept to response transaction, receiver ready):
//   append or rejected request: S_DONE, then the output register; read or
//   overwrite: S_RDWAIT, S_DONE, then the output register; remove: as read,
//   plus S_SHIFT before S_DONE if entries follow the removed one; they move
//   down one place per cycle through the memory's single read and write
//   port.
// Flow: one request at a time; the next is accepted the cycle after
//   the response is loaded.
// Reset: the entry count clears to zero; memory contents are not cleared and
//   need no clearing pass, as only written entries are ever read.
// Stall: a response waits in the output register while the receiver holds
//   ready low; a finished request waits behind it and no new one is taken.
// ----------------------------------------------------------------------------
module indexed_sequence_store_unit
	import isu_pkg::*;
#(
	parameter int unsigned DEPTH     = DEPTH_DEF,
	parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	isu_req_if.sink   req,
	isu_rsp_if.source rsp
);

	localparam int unsigned AW = $clog2(DEPTH);

	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	logic [WORD_BITS-1:0] wr_data;
	logic                 rd_en;
	logic [AW-1:0]        rd_addr;
	logic [WORD_BITS-1:0] rd_data;

	// Sequencer
	isu_ctrl #(
		.DEPTH     (DEPTH),
		.WORD_BITS (WORD_BITS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Entry storage
	isu_mem #(
		.DEPTH     (DEPTH),
		.WORD_BITS (WORD_BITS)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

endmodule
